@@ design/ast_pkg.sv @@
// ----------------------------------------------------------------------------
// Attained service tracker package
// Shared types and constants for the attained service tracker.
// ----------------------------------------------------------------------------
package ast_pkg;

  // Command codes carried in the operation field.
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_ACT   = 2'd1,
    OP_PRE   = 2'd2,
    OP_OTHER = 2'd3
  } ast_op_t;

  localparam int unsigned SERVICE_W = 48;
  localparam int unsigned OWNED_W   = 7;
  localparam int unsigned QLEN_W    = 32;

  localparam logic [SERVICE_W-1:0] SERVICE_MAX = {SERVICE_W{1'b1}};
  localparam logic [OWNED_W-1:0]   OWNED_MAX   = {OWNED_W{1'b1}};
  localparam logic [QLEN_W-1:0]    QLEN_RESET  = 32'd10000000;

  // One request on the input channel.
  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] bank;
    logic [2:0] thread;
  } ast_in_t;

  // One result on the output channel.
  typedef struct packed {
    logic [2:0]           thread_id;
    logic [SERVICE_W-1:0] attained_service;
    logic                 last;
  } ast_out_t;

  // Registered request as seen by the update stage.
  typedef struct packed {
    logic    valid;
    logic    close;
    ast_in_t item;
  } ast_stage_t;

endpackage

@@ design/attained_service_tracker.sv @@
// ----------------------------------------------------------------------------
// Attained service tracker
// Per thread bank-cycle accounting with a report of every thread per quantum.
// ----------------------------------------------------------------------------
// Report: a request closing a quantum passes the input register and the report
// counter load; then the result register gives one result per cycle, one per thread.
// Throughput: one request per cycle; busy rises only for a request that would
// close a quantum while a closing request sits in the input register or the
// previous report has more than one result left. The receiver cannot stall results.
// Reset (rst_n, synchronous, active low) clears ownership, counts and service.
module attained_service_tracker #(
  parameter int NUM_BANKS   = 64,
  parameter int NUM_THREADS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ast_pkg::ast_in_t    in_item,
  output logic                out_valid,
  output ast_pkg::ast_out_t   out_result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  logic [ast_pkg::QLEN_W-1:0] qlen_r;
  logic [ast_pkg::QLEN_W-1:0] qcount_r;
  logic [ast_pkg::QLEN_W-1:0] qcount_inc;
  logic                       close_next;
  logic                       accept;
  logic                       many_left;
  ast_pkg::ast_stage_t        stage_r;
  ast_pkg::ast_stage_t        stage_nxt;
  logic [NUM_THREADS-1:0][ast_pkg::OWNED_W-1:0]   banks_owned;
  logic [NUM_THREADS-1:0][ast_pkg::SERVICE_W-1:0] snapshot;

  // Quantum boundary decision for the next request.
  assign qcount_inc = qcount_r + 1'b1;
  assign close_next = (qcount_inc >= qlen_r);
  assign busy       = close_next && ((stage_r.valid && stage_r.close) || many_left);
  assign accept     = start && !busy;
  assign cfg_ready  = !stage_r.valid && !start;

  // Quantum length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= ast_pkg::QLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      qlen_r <= cfg_data;
    end
  end

  // Quantum counter advances once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcount_r <= '0;
    end else if (accept) begin
      qcount_r <= close_next ? '0 : qcount_inc;
    end
  end

  // Input register feeding the update stage.
  always_comb begin
    stage_nxt.valid = accept;
    stage_nxt.close = close_next;
    stage_nxt.item  = in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.close <= stage_nxt.close;
    stage_r.item  <= stage_nxt.item;
  end

  ast_owner #(
    .NUM_BANKS   (NUM_BANKS),
    .NUM_THREADS (NUM_THREADS)
  ) u_owner (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rd_bank     (in_item.bank),
    .stage       (stage_r),
    .banks_owned (banks_owned)
  );

  ast_service #(
    .NUM_THREADS (NUM_THREADS)
  ) u_service (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage_r),
    .banks_owned (banks_owned),
    .snapshot    (snapshot)
  );

  ast_report #(
    .NUM_THREADS (NUM_THREADS)
  ) u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (stage_r.valid && stage_r.close),
    .snapshot   (snapshot),
    .many_left  (many_left),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

@@ design/ast_owner.sv @@
// ----------------------------------------------------------------------------
// Bank ownership tracker
// Keeps the owner of every bank and the number of banks each thread owns.
// ----------------------------------------------------------------------------
module ast_owner #(
  parameter int NUM_BANKS   = 64,
  parameter int NUM_THREADS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [5:0]           rd_bank,
  input  ast_pkg::ast_stage_t  stage,
  output logic [NUM_THREADS-1:0][ast_pkg::OWNED_W-1:0] banks_owned
);

  localparam int BANK_AW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  logic [2:0]              owner_mem [NUM_BANKS];
  logic [NUM_BANKS-1:0]    owner_valid_r;
  logic [2:0]              rd_data_r;
  logic                    fwd_r;
  logic [2:0]              fwd_thread_r;
  logic [NUM_THREADS-1:0][ast_pkg::OWNED_W-1:0] owned_r;
  logic [NUM_THREADS-1:0][ast_pkg::OWNED_W-1:0] owned_nxt;

  logic [BANK_AW-1:0] st_idx;
  logic               bank_ok;
  logic               thread_ok;
  logic               cur_valid;
  logic               act_ok;
  logic               pre_ok;
  logic [2:0]         old_owner;

  // Decode the request in the update stage.
  always_comb begin
    st_idx    = BANK_AW'(stage.item.bank);
    bank_ok   = (32'(stage.item.bank) < NUM_BANKS);
    thread_ok = (32'(stage.item.thread) < NUM_THREADS);
    cur_valid = owner_valid_r[st_idx];
    act_ok    = stage.valid && bank_ok && thread_ok &&
                (stage.item.operation == ast_pkg::OP_ACT);
    pre_ok    = stage.valid && bank_ok && cur_valid &&
                (stage.item.operation == ast_pkg::OP_PRE);
    old_owner = fwd_r ? fwd_thread_r : rd_data_r;
  end

  // Owner table: read at accept, written by activates in the update stage.
  always_ff @(posedge clk) begin
    rd_data_r <= owner_mem[BANK_AW'(rd_bank)];
    if (act_ok) begin
      owner_mem[st_idx] <= stage.item.thread;
    end
  end

  // Forward an owner written in the same cycle as the read of that bank.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= accept && act_ok && (BANK_AW'(rd_bank) == st_idx);
    end
    fwd_thread_r <= stage.item.thread;
  end

  // Valid bit per bank.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_valid_r <= '0;
    end else if (act_ok) begin
      owner_valid_r[st_idx] <= 1'b1;
    end else if (pre_ok) begin
      owner_valid_r[st_idx] <= 1'b0;
    end
  end

  // Per thread count: the old owner drops the bank first, then the new one gains it.
  always_comb begin
    logic                         drop;
    logic                         gain;
    logic [ast_pkg::OWNED_W-1:0]  c1;
    for (int t = 0; t < NUM_THREADS; t++) begin
      drop = (act_ok || pre_ok) && cur_valid && (32'(old_owner) == t);
      gain = act_ok && (32'(stage.item.thread) == t);
      c1   = owned_r[t];
      if (drop && (c1 != '0)) begin
        c1 = c1 - 1'b1;
      end
      if (gain && (c1 != ast_pkg::OWNED_MAX)) begin
        c1 = c1 + 1'b1;
      end
      owned_nxt[t] = c1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owned_r <= '0;
    end else begin
      owned_r <= owned_nxt;
    end
  end

  assign banks_owned = owned_r;

endmodule

@@ design/ast_service.sv @@
// ----------------------------------------------------------------------------
// Service accumulators
// Saturating per thread bank-cycle counters, cleared when a quantum closes.
// ----------------------------------------------------------------------------
module ast_service #(
  parameter int NUM_THREADS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ast_pkg::ast_stage_t  stage,
  input  logic [NUM_THREADS-1:0][ast_pkg::OWNED_W-1:0]   banks_owned,
  output logic [NUM_THREADS-1:0][ast_pkg::SERVICE_W-1:0] snapshot
);

  logic [NUM_THREADS-1:0][ast_pkg::SERVICE_W-1:0] accum_r;
  logic [NUM_THREADS-1:0][ast_pkg::SERVICE_W-1:0] accum_nxt;

  // Grow each accumulator by its thread's bank count, saturating.
  always_comb begin
    logic [ast_pkg::SERVICE_W:0] sum;
    for (int t = 0; t < NUM_THREADS; t++) begin
      sum = {1'b0, accum_r[t]} + (ast_pkg::SERVICE_W + 1)'(banks_owned[t]);
      snapshot[t] = sum[ast_pkg::SERVICE_W] ? ast_pkg::SERVICE_MAX
                                            : sum[ast_pkg::SERVICE_W-1:0];
      if (!stage.valid) begin
        accum_nxt[t] = accum_r[t];
      end else if (stage.close) begin
        accum_nxt[t] = '0;
      end else begin
        accum_nxt[t] = snapshot[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else begin
      accum_r <= accum_nxt;
    end
  end

endmodule

@@ design/ast_report.sv @@
// ----------------------------------------------------------------------------
// Service report serializer
// Captures all threads' service at a quantum close and sends one per cycle.
// ----------------------------------------------------------------------------
module ast_report #(
  parameter int NUM_THREADS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic [NUM_THREADS-1:0][ast_pkg::SERVICE_W-1:0] snapshot,
  output logic                 many_left,
  output logic                 out_valid,
  output ast_pkg::ast_out_t    out_result
);

  localparam int CW = $clog2(NUM_THREADS + 1);
  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

  logic [NUM_THREADS-1:0][ast_pkg::SERVICE_W-1:0] buf_r;
  logic [CW-1:0]        cnt_r;
  logic [TW-1:0]        idx_r;
  logic                 out_valid_r;
  ast_pkg::ast_out_t    out_r;

  // Remaining-entry count and thread index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      cnt_r       <= CW'(NUM_THREADS);
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r       <= cnt_r - 1'b1;
      idx_r       <= idx_r + 1'b1;
      out_valid_r <= 1'b1;
    end else begin
      out_valid_r <= 1'b0;
    end
  end

  // Shift line of captured values; the head goes to the result register.
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= snapshot;
    end else if (cnt_r != '0) begin
      for (int i = 0; i < NUM_THREADS - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
      out_r.thread_id        <= 3'(idx_r);
      out_r.attained_service <= buf_r[0];
      out_r.last             <= (cnt_r == CW'(1));
    end
  end

  assign many_left  = (cnt_r > CW'(1));
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

@@ verif/service_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Attained service checker
// Watches the request, result and configuration channels of the tracker. It
// keeps its own copy of bank ownership, per thread service and the quantum
// count, predicts each quantum report and compares the reports field by field.
// ----------------------------------------------------------------------------
module service_checker #(
  parameter int NUM_BANKS   = 64,
  parameter int NUM_THREADS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  ast_pkg::ast_in_t  in_item,
  input  logic              out_valid,
  input  ast_pkg::ast_out_t out_result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  output int                fail_count,
  output int                pending
);

  // Shadow state of the tracker.
  logic                          bank_held  [NUM_BANKS];
  logic [2:0]                    bank_owner [NUM_BANKS];
  logic [ast_pkg::OWNED_W-1:0]   held_count [NUM_THREADS];
  logic [ast_pkg::SERVICE_W-1:0] service    [NUM_THREADS];
  logic [ast_pkg::QLEN_W-1:0]    cycle_in_quantum;
  logic [ast_pkg::QLEN_W-1:0]    quantum_len;

  // Report entries still to come, oldest first.
  ast_pkg::ast_out_t reports_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin : track
    ast_pkg::ast_out_t due;
    if (!rst_n) begin
      quantum_len      = ast_pkg::QLEN_RESET;
      cycle_in_quantum = '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
        bank_held[b]  = 1'b0;
        bank_owner[b] = '0;
      end
      for (int t = 0; t < NUM_THREADS; t++) begin
        held_count[t] = '0;
        service[t]    = '0;
      end
      reports_due.delete();
    end else begin
      // Results seen at this edge belong to earlier requests, so compare first.
      if (out_valid) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got thread %0d service %0d last %0b",
                   $time, out_result.thread_id, out_result.attained_service, out_result.last);
          fail_count++;
        end else begin
          due = reports_due.pop_front();
          if (out_result.thread_id !== due.thread_id) begin
            $display("%0t: thread_id expected %0d, got %0d",
                     $time, due.thread_id, out_result.thread_id);
            fail_count++;
          end
          if (out_result.attained_service !== due.attained_service) begin
            $display("%0t: attained_service of thread %0d expected %0d, got %0d",
                     $time, due.thread_id, due.attained_service, out_result.attained_service);
            fail_count++;
          end
          if (out_result.last !== due.last) begin
            $display("%0t: last of thread %0d expected %0b, got %0b",
                     $time, due.thread_id, due.last, out_result.last);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) quantum_len = cfg_data;

      if (start && !busy) begin
        // Every thread is charged for the banks it holds during this cycle.
        for (int t = 0; t < NUM_THREADS; t++) begin
          if (service[t] > ast_pkg::SERVICE_MAX - (ast_pkg::SERVICE_W)'(held_count[t]))
            service[t] = ast_pkg::SERVICE_MAX;
          else
            service[t] = service[t] + (ast_pkg::SERVICE_W)'(held_count[t]);
        end

        // An activate moves the bank to the issuing thread; a precharge frees it.
        if (in_item.bank < NUM_BANKS) begin
          if (in_item.operation == ast_pkg::OP_ACT && in_item.thread < NUM_THREADS) begin
            if (bank_held[in_item.bank] && held_count[bank_owner[in_item.bank]] > 0)
              held_count[bank_owner[in_item.bank]]--;
            bank_held[in_item.bank]  = 1'b1;
            bank_owner[in_item.bank] = in_item.thread;
            if (held_count[in_item.thread] < ast_pkg::OWNED_MAX)
              held_count[in_item.thread]++;
          end else if (in_item.operation == ast_pkg::OP_PRE && bank_held[in_item.bank]) begin
            bank_held[in_item.bank] = 1'b0;
            if (held_count[bank_owner[in_item.bank]] > 0)
              held_count[bank_owner[in_item.bank]]--;
          end
        end

        // Closing a quantum reports every thread in order and clears the service.
        cycle_in_quantum = cycle_in_quantum + 1'b1;
        if (cycle_in_quantum >= quantum_len) begin
          cycle_in_quantum = '0;
          for (int t = 0; t < NUM_THREADS; t++) begin
            due.thread_id        = 3'(t);
            due.attained_service = service[t];
            due.last             = (t == NUM_THREADS - 1);
            reports_due.push_back(due);
            service[t] = '0;
          end
        end
      end
    end
    pending = reports_due.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Attained service tracker testbench
// Drives directed and random activate, precharge and idle requests through
// several quantum lengths, with random gaps, and lets the checker compare
// every quantum report against its own prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  ast_pkg::ast_in_t  in_item   = '0;
  logic              out_valid;
  ast_pkg::ast_out_t out_result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_data  = '0;
  int                fail_count;
  int                pending;
  int                cycle_count = 0;
  bit                quiet = 1'b0;

  // Quantum length and bank window of each random phase.
  logic [31:0] phase_len  [8] = '{32'hFFFF_FFFF, 32'd3, 32'd2, 32'd1,
                                  32'd7, 32'd16, 32'd5, 32'd1};
  int          phase_span [8] = '{8, 4, 64, 8, 16, 8, 4, 64};

  always #5 clk = ~clk;

  attained_service_tracker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  service_checker service_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Issue one request, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_request(input ast_pkg::ast_in_t r);
    if (!quiet) begin
      while ($urandom_range(99) < 21) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    in_item <= r;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_cmd(input ast_pkg::ast_op_t op, input int b, input int t);
    ast_pkg::ast_in_t r;
    r.operation = op;
    r.bank      = 6'(b);
    r.thread    = 3'(t);
    send_request(r);
  endtask

  // Wait until every report has arrived and the pipeline has drained.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quantum_length(input logic [31:0] len);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    ast_pkg::ast_in_t req;
    int               pick;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ownership corner cases under the reset quantum length, so no report yet.
    send_cmd(ast_pkg::OP_ACT,   0,  0);
    send_cmd(ast_pkg::OP_ACT,   63, 7);
    send_cmd(ast_pkg::OP_ACT,   0,  3);   // owned bank taken over by another thread
    send_cmd(ast_pkg::OP_ACT,   63, 7);   // owned bank activated again by its owner
    send_cmd(ast_pkg::OP_PRE,   10, 1);   // precharge of a bank nobody holds
    send_cmd(ast_pkg::OP_OTHER, 42, 5);   // other commands act as idle ticks
    send_cmd(ast_pkg::OP_IDLE,  21, 2);
    send_cmd(ast_pkg::OP_ACT,   42, 5);
    send_cmd(ast_pkg::OP_ACT,   21, 2);
    send_cmd(ast_pkg::OP_PRE,   0,  0);
    send_cmd(ast_pkg::OP_ACT,   1,  7);
    send_cmd(ast_pkg::OP_PRE,   63, 0);
    settle();

    // Lowering the length below the cycles counted closes the quantum at once.
    write_quantum_length(32'd1);
    send_cmd(ast_pkg::OP_IDLE,  0,  0);
    send_cmd(ast_pkg::OP_ACT,   62, 4);
    send_cmd(ast_pkg::OP_OTHER, 63, 7);
    send_cmd(ast_pkg::OP_PRE,   42, 5);
    send_cmd(ast_pkg::OP_PRE,   42, 5);   // bank already freed

    // Random phases: mostly activates and precharges on each phase's bank window.
    for (int p = 0; p < 8; p++) begin
      settle();
      write_quantum_length(phase_len[p]);
      quiet = (p == 3);
      repeat (42) begin
        pick = $urandom_range(99);
        if (pick < 38)      req.operation = ast_pkg::OP_ACT;
        else if (pick < 76) req.operation = ast_pkg::OP_PRE;
        else if (pick < 92) req.operation = ast_pkg::OP_IDLE;
        else                req.operation = ast_pkg::OP_OTHER;
        if ($urandom_range(9) == 0)
          req.bank = 6'($urandom_range(63));
        else
          req.bank = 6'($urandom_range(phase_span[p] - 1));
        req.thread = 3'($urandom_range(7));
        send_request(req);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
